### sv/rcs_pkg.sv
// Package for the running column statistics unit: defaults, codes, state and flag types.
`default_nettype none

package rcs_pkg;

    // Default widths handed to the top level parameters
    localparam int DEF_SAMPLE_BITS = 32;
    localparam int DEF_COUNT_BITS  = 24;

    // Slope tolerance register, fraction of 2^TOL_BITS
    localparam int              TOL_BITS  = 16;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd66;

    // Input action codes; the unused code behaves as ACT_FINISH
    localparam logic [1:0] ACT_SAMPLE        = 2'd0;
    localparam logic [1:0] ACT_SAMPLE_FINISH = 2'd1;
    localparam logic [1:0] ACT_FINISH        = 2'd2;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SUBD,
        ST_ABS1,
        ST_ADDD,
        ST_ABS2,
        ST_MUL,
        ST_CMP,
        ST_SUM,
        ST_FIN,
        ST_DIV,
        ST_NEG,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic count_overflow;
        logic empty_error;
        logic slope_constant;
        logic is_sorted;
    } rcs_flags_t;

endpackage

`default_nettype wire

### sv/rcs_alu.sv
// Shared add/subtract unit used by every arithmetic step of the sequencer but the tolerance multiply.
`default_nettype none

module rcs_alu #(
    parameter int WIDTH = 64
) (
    input  rcs_pkg::alu_op_t         op,
    input  logic signed [WIDTH-1:0]  a,
    input  logic signed [WIDTH-1:0]  b,
    output logic signed [WIDTH-1:0]  y
);
    import rcs_pkg::*;

    always_comb begin
        case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            default: y = a + b;
        endcase
    end

endmodule

`default_nettype wire

### sv/rcs_out_buf.sv
// Output register for result transactions: packs the fields and holds them until taken.
`default_nettype none

module rcs_out_buf #(
    parameter int SAMPLE_BITS = 32,
    parameter int COUNT_BITS  = 24,
    localparam int FIELD_BITS = 3 * SAMPLE_BITS + COUNT_BITS + 4,
    localparam int DATA_W     = ((FIELD_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  logic [SAMPLE_BITS-1:0]   average,
    input  logic [SAMPLE_BITS-1:0]   minimum,
    input  logic [SAMPLE_BITS-1:0]   maximum,
    input  logic [COUNT_BITS-1:0]    sample_count,
    input  rcs_pkg::rcs_flags_t      flags,
    output logic                     space,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [DATA_W-1:0]        m_tdata
);
    import rcs_pkg::*;

    logic              valid_reg, valid_next;
    logic [DATA_W-1:0] data_reg, data_next;

    assign space    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            data_next  = DATA_W'({flags.count_overflow, flags.empty_error,
                                  flags.slope_constant, flags.is_sorted,
                                  sample_count, maximum, minimum, average});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

### sv/running_column_statistics_unit.sv
// Top level of the running column statistics unit: sequencer, run state and config register.
`default_nettype none

// Running column statistics. Each input transaction carries an action in s_tuser
// (sample, sample then finish, finish) and a signed fixed-point sample in s_tdata.
// The unit keeps min, max, a full-precision sum and a saturating count of the run,
// plus a sorted flag (every step strictly rising) and a constant-slope flag
// (2*|d-dprev| <= tol/65536 * |d+dprev| for every pair of consecutive steps).
// On finish one result transaction is produced: truncated mean, min, max, count
// and the flags; an empty run gives zeros with empty_error set. The run state then
// clears; slope_tolerance keeps its value. The data arithmetic goes through a single
// shared adder/subtractor, bar the tolerance multiply, so the unit takes one
// transaction at a time: the first two samples of a run take the difference and the
// sum, every later one the difference, two absolute slope terms, tolerance multiply,
// compare and sum. A finish is dominated by the restoring divider that reuses the
// same adder one quotient bit per cycle; a finish of an empty run skips the divider.
// The last step of a finish waits until the previous result has been taken. A result
// waits in its own output register, so the next run may start while it is still
// pending. slope_tolerance is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while the unit is idle, as the unit itself does not enforce this.

module running_column_statistics_unit #(
    parameter int SAMPLE_BITS = rcs_pkg::DEF_SAMPLE_BITS,
    parameter int COUNT_BITS  = rcs_pkg::DEF_COUNT_BITS,
    localparam int IN_W       = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((3 * SAMPLE_BITS + COUNT_BITS + 4 + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // slope tolerance register
    input  logic                          cfg_wr_en,
    input  logic [rcs_pkg::TOL_BITS-1:0]  cfg_wr_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_W-1:0]               s_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic [1:0]                    s_tuser,   // [1:0] action
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_W-1:0]              m_tdata    // average, minimum, maximum,
                                                     // sample_count, is_sorted,
                                                     // slope_constant, empty_error,
                                                     // count_overflow
);
    import rcs_pkg::*;

    localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
    localparam int MAG_BITS  = SUM_BITS - 1;
    localparam int D_BITS    = SAMPLE_BITS + 1;
    localparam int T_BITS    = SAMPLE_BITS + 2;
    localparam int PROD_BITS = T_BITS + TOL_BITS;
    localparam int LHS_BITS  = T_BITS + TOL_BITS + 1;
    localparam int AW        = (SUM_BITS + 1 > LHS_BITS + 1) ? SUM_BITS + 1 : LHS_BITS + 1;
    localparam int ITER_BITS = $clog2(MAG_BITS + 1);

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0]         C_MAX = {COUNT_BITS{1'b1}};

    state_t                          state_reg, state_next;
    logic [TOL_BITS-1:0]             tol_reg, tol_next;
    logic [1:0]                      action_reg, action_next;
    logic signed [SAMPLE_BITS-1:0]   sample_reg, sample_next;
    logic signed [SAMPLE_BITS-1:0]   prev_reg, prev_next;
    logic signed [D_BITS-1:0]        dprev_reg, dprev_next;
    logic signed [D_BITS-1:0]        d_reg, d_next;
    logic signed [T_BITS-1:0]        acc_reg, acc_next;
    logic [T_BITS-1:0]               mag1_reg, mag1_next;
    logic [T_BITS-1:0]               mag2_reg, mag2_next;
    logic [PROD_BITS-1:0]            prod_reg, prod_next;
    logic signed [SUM_BITS-1:0]      sum_reg, sum_next;
    logic [COUNT_BITS-1:0]           count_reg, count_next;
    logic signed [SAMPLE_BITS-1:0]   min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0]   max_reg, max_next;
    logic                            sorted_reg, sorted_next;
    logic                            const_reg, const_next;
    logic                            ovf_reg, ovf_next;
    logic                            neg_reg, neg_next;
    logic                            empty_reg, empty_next;
    logic [MAG_BITS-1:0]             dvd_reg, dvd_next;
    logic [COUNT_BITS-1:0]           rem_reg, rem_next;
    logic [ITER_BITS-1:0]            iter_reg, iter_next;
    logic signed [SAMPLE_BITS-1:0]   avg_reg, avg_next;

    alu_op_t                         alu_op;
    logic signed [AW-1:0]            alu_a, alu_b, alu_y;
    logic signed [D_BITS-1:0]        d_now;
    logic [COUNT_BITS:0]             shifted;
    logic [LHS_BITS-1:0]             lhs;
    logic                            out_load, out_space;
    logic [SAMPLE_BITS-1:0]          out_min, out_max;
    rcs_flags_t                      out_flags;

    assign d_now   = alu_y[D_BITS-1:0];
    assign shifted = {rem_reg, dvd_reg[MAG_BITS-1]};
    assign lhs     = {mag1_reg, {(TOL_BITS+1){1'b0}}};
    assign s_tready = (state_reg == ST_IDLE);

    rcs_alu #(
        .WIDTH (AW)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    // Operand selection for the shared adder
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (state_reg)
            ST_DIFF: begin
                alu_op = ALU_SUB;
                alu_a  = AW'(sample_reg);
                alu_b  = AW'(prev_reg);
            end
            ST_SUBD: begin
                alu_op = ALU_SUB;
                alu_a  = AW'(d_reg);
                alu_b  = AW'(dprev_reg);
            end
            ST_ADDD: begin
                alu_op = ALU_ADD;
                alu_a  = AW'(d_reg);
                alu_b  = AW'(dprev_reg);
            end
            ST_ABS1, ST_ABS2: begin
                alu_op = ALU_SUB;
                alu_b  = AW'(acc_reg);
            end
            ST_CMP: begin
                alu_op = ALU_SUB;
                alu_a  = AW'(prod_reg);
                alu_b  = AW'(lhs);
            end
            ST_SUM: begin
                alu_op = ALU_ADD;
                alu_a  = AW'(sum_reg);
                alu_b  = AW'(sample_reg);
            end
            ST_FIN: begin
                alu_op = ALU_SUB;
                alu_b  = AW'(sum_reg);
            end
            ST_DIV: begin
                alu_op = ALU_SUB;
                alu_a  = AW'(shifted);
                alu_b  = AW'(count_reg);
            end
            ST_NEG: begin
                alu_op = ALU_SUB;
                alu_b  = AW'(dvd_reg);
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    // Sequencer and run state
    always_comb begin
        state_next  = state_reg;
        tol_next    = tol_reg;
        action_next = action_reg;
        sample_next = sample_reg;
        prev_next   = prev_reg;
        dprev_next  = dprev_reg;
        d_next      = d_reg;
        acc_next    = acc_reg;
        mag1_next   = mag1_reg;
        mag2_next   = mag2_reg;
        prod_next   = prod_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        sorted_next = sorted_reg;
        const_next  = const_reg;
        ovf_next    = ovf_reg;
        neg_next    = neg_reg;
        empty_next  = empty_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        iter_next   = iter_reg;
        avg_next    = avg_reg;
        out_load    = 1'b0;

        if (cfg_wr_en) begin
            tol_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sample_next = s_tdata[SAMPLE_BITS-1:0];
                    action_next = s_tuser;
                    if (s_tuser inside {ACT_SAMPLE, ACT_SAMPLE_FINISH}) begin
                        state_next = ST_DIFF;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_DIFF: begin
                d_next = d_now;
                if (sample_reg > max_reg) begin
                    max_next = sample_reg;
                end
                if (sample_reg < min_reg) begin
                    min_next = sample_reg;
                end
                if (count_reg == '0) begin
                    state_next = ST_SUM;
                end else begin
                    if (d_now <= 0) begin
                        sorted_next = 1'b0;
                    end
                    if (count_reg == COUNT_BITS'(1)) begin
                        dprev_next = d_now;
                        state_next = ST_SUM;
                    end else begin
                        state_next = ST_SUBD;
                    end
                end
            end
            ST_SUBD: begin
                acc_next   = alu_y[T_BITS-1:0];
                state_next = ST_ABS1;
            end
            ST_ABS1: begin
                mag1_next  = acc_reg[T_BITS-1] ? alu_y[T_BITS-1:0] : acc_reg;
                state_next = ST_ADDD;
            end
            ST_ADDD: begin
                acc_next   = alu_y[T_BITS-1:0];
                state_next = ST_ABS2;
            end
            ST_ABS2: begin
                mag2_next  = acc_reg[T_BITS-1] ? alu_y[T_BITS-1:0] : acc_reg;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = PROD_BITS'(mag2_reg) * PROD_BITS'(tol_reg);
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // negative difference: left side above the tolerance product
                if (alu_y[AW-1]) begin
                    const_next = 1'b0;
                end
                dprev_next = d_reg;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (count_reg == C_MAX) begin
                    ovf_next = 1'b1;
                end else begin
                    count_next = count_reg + COUNT_BITS'(1);
                    sum_next   = alu_y[SUM_BITS-1:0];
                end
                prev_next = sample_reg;
                if (action_reg == ACT_SAMPLE_FINISH) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN: begin
                if (count_reg == '0) begin
                    empty_next = 1'b1;
                    avg_next   = '0;
                    state_next = ST_EMIT;
                end else begin
                    empty_next = 1'b0;
                    neg_next   = sum_reg[SUM_BITS-1];
                    dvd_next   = sum_reg[SUM_BITS-1] ? alu_y[MAG_BITS-1:0]
                                                     : sum_reg[MAG_BITS-1:0];
                    rem_next   = '0;
                    iter_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // restoring step: quotient bits shift in behind the dividend
                if (!alu_y[AW-1]) begin
                    rem_next = alu_y[COUNT_BITS-1:0];
                    dvd_next = {dvd_reg[MAG_BITS-2:0], 1'b1};
                end else begin
                    rem_next = shifted[COUNT_BITS-1:0];
                    dvd_next = {dvd_reg[MAG_BITS-2:0], 1'b0};
                end
                iter_next = iter_reg + ITER_BITS'(1);
                if (iter_reg == ITER_BITS'(MAG_BITS - 1)) begin
                    state_next = ST_NEG;
                end
            end
            ST_NEG: begin
                avg_next   = neg_reg ? alu_y[SAMPLE_BITS-1:0] : dvd_reg[SAMPLE_BITS-1:0];
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_space) begin
                    out_load    = 1'b1;
                    min_next    = S_MAX;
                    max_next    = S_MIN;
                    sum_next    = '0;
                    count_next  = '0;
                    prev_next   = '0;
                    dprev_next  = '0;
                    sorted_next = 1'b1;
                    const_next  = 1'b1;
                    ovf_next    = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tol_reg    <= TOL_RESET;
            prev_reg   <= '0;
            dprev_reg  <= '0;
            sum_reg    <= '0;
            count_reg  <= '0;
            min_reg    <= S_MAX;
            max_reg    <= S_MIN;
            sorted_reg <= 1'b1;
            const_reg  <= 1'b1;
            ovf_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            tol_reg    <= tol_next;
            prev_reg   <= prev_next;
            dprev_reg  <= dprev_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            sorted_reg <= sorted_next;
            const_reg  <= const_next;
            ovf_reg    <= ovf_next;
        end
        action_reg <= action_next;
        sample_reg <= sample_next;
        d_reg      <= d_next;
        acc_reg    <= acc_next;
        mag1_reg   <= mag1_next;
        mag2_reg   <= mag2_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        empty_reg  <= empty_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        iter_reg   <= iter_next;
        avg_reg    <= avg_next;
    end

    // Empty run reports zero extremes
    assign out_min = empty_reg ? '0 : min_reg;
    assign out_max = empty_reg ? '0 : max_reg;
    assign out_flags.count_overflow = ovf_reg;
    assign out_flags.empty_error    = empty_reg;
    assign out_flags.slope_constant = const_reg;
    assign out_flags.is_sorted      = sorted_reg;

    rcs_out_buf #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_out_buf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (out_load),
        .average      (avg_reg),
        .minimum      (out_min),
        .maximum      (out_max),
        .sample_count (count_reg),
        .flags        (out_flags),
        .space        (out_space),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

`ifndef SYNTH
    // overflow can only be marked once the count is pinned at its ceiling
    a_ovf_at_ceiling: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (count_reg == C_MAX))
        else $error("overflow mark without saturated count");

    // no slope pair exists before the second sample
    a_const_short_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && count_reg < COUNT_BITS'(2)) |-> (const_reg && sorted_reg))
        else $error("flag cleared in a run of fewer than two samples");

    // extremes stay ordered once a sample has been taken
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && count_reg != '0) |-> (min_reg <= max_reg))
        else $error("run minimum above run maximum");

    // the divider always leaves after the last quotient bit
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && iter_reg == ITER_BITS'(MAG_BITS - 1)) |=> (state_reg == ST_NEG))
        else $error("divider ran past its last step");
`endif

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the running column statistics unit: run predictor, scoreboard, stimulus.
`timescale 1ns / 100ps

module testbench;
    import rcs_pkg::*;

    localparam int SAMPLE_W  = DEF_SAMPLE_BITS;
    localparam int COUNT_W   = DEF_COUNT_BITS;
    localparam int IN_W      = ((SAMPLE_W + 7) / 8) * 8;
    localparam int SUMMARY_W = 3 * SAMPLE_W + COUNT_W + 4;
    localparam int OUT_W     = ((SUMMARY_W + 7) / 8) * 8;

    // the spare action code; the unit treats it as a plain finish
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // quiet time before a register write: one full sample plus a finish, with margin
    localparam int SETTLE_CYCLES = 80;
    // drain time after the last result
    localparam int TAIL_CYCLES   = 100;
    // cycles without any transaction before the run is declared hung;
    // well above the long receiver hold-off used for back-pressure
    localparam int QUIET_LIMIT   = 10000;
    localparam int HOLD_CYCLES   = 1500;

    // one result transaction, last field in the lowest bits
    typedef struct packed {
        rcs_flags_t            flags;
        logic [COUNT_W-1:0]    sample_count;
        logic [SAMPLE_W-1:0]   maximum;
        logic [SAMPLE_W-1:0]   minimum;
        logic [SAMPLE_W-1:0]   average;
    } run_summary_t;

    // Run predictor and scoreboard. Folds every accepted sample into its own copy of the
    // run state and queues the summary that a finish should produce.
    class run_stats_board;
        run_summary_t              awaited_summaries[$];
        int                        faults;
        int                        summaries_seen;
        logic [TOL_BITS-1:0]       tolerance;
        logic signed [SAMPLE_W-1:0] run_min;
        logic signed [SAMPLE_W-1:0] run_max;
        logic signed [SAMPLE_W-1:0] prev_sample;
        logic signed [SAMPLE_W:0]   prev_slope;
        longint                    run_sum;
        logic [COUNT_W-1:0]        run_count;
        bit                        sorted_mark;
        bit                        constant_mark;
        bit                        overflow_mark;

        function new();
            tolerance      = TOL_RESET;
            faults         = 0;
            summaries_seen = 0;
            clear_run();
        endfunction

        function void clear_run();
            run_max       = {1'b1, {(SAMPLE_W - 1){1'b0}}};
            run_min       = {1'b0, {(SAMPLE_W - 1){1'b1}}};
            run_sum       = 0;
            run_count     = '0;
            prev_sample   = '0;
            prev_slope    = '0;
            sorted_mark   = 1'b1;
            constant_mark = 1'b1;
            overflow_mark = 1'b0;
        endfunction

        function void set_tolerance(logic [TOL_BITS-1:0] value);
            tolerance = value;
        endfunction

        function longint unsigned abs_wide(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function void fold_sample(logic signed [SAMPLE_W-1:0] s);
            logic signed [SAMPLE_W:0] slope;
            longint unsigned          lhs;
            longint unsigned          rhs;
            if (s > run_max) run_max = s;
            if (s < run_min) run_min = s;
            if (run_count != 0) begin
                slope = s - prev_sample;
                if (slope <= 0) sorted_mark = 1'b0;
                if (run_count > 1) begin
                    // 2*|d-dprev| against tol/2^16 * |d+dprev|, both scaled by 2^16
                    lhs = abs_wide(longint'(slope) - longint'(prev_slope)) << (TOL_BITS + 1);
                    rhs = abs_wide(longint'(slope) + longint'(prev_slope))
                          * longint'(tolerance);
                    if (lhs > rhs) constant_mark = 1'b0;
                end
                prev_slope = slope;
            end
            // saturated count: sample still shapes min, max and flags but is not summed
            if (run_count == '1) begin
                overflow_mark = 1'b1;
            end else begin
                run_count = run_count + 1'b1;
                run_sum   = run_sum + longint'(s);
            end
            prev_sample = s;
        endfunction

        function run_summary_t close_run();
            run_summary_t r;
            longint       mean;
            r = '0;
            if (run_count == 0) begin
                r.flags.empty_error    = 1'b1;
                r.flags.is_sorted      = 1'b1;
                r.flags.slope_constant = 1'b1;
            end else begin
                mean                   = run_sum / longint'(run_count);
                r.average              = mean[SAMPLE_W-1:0];
                r.minimum              = run_min;
                r.maximum              = run_max;
                r.sample_count         = run_count;
                r.flags.is_sorted      = sorted_mark;
                r.flags.slope_constant = constant_mark;
                r.flags.count_overflow = overflow_mark;
            end
            clear_run();
            return r;
        endfunction

        function void note_item(logic [1:0] action, logic [IN_W-1:0] word);
            if (action == ACT_SAMPLE || action == ACT_SAMPLE_FINISH)
                fold_sample(word[SAMPLE_W-1:0]);
            if (action != ACT_SAMPLE)
                awaited_summaries.push_back(close_run());
        endfunction

        function void note_fault(string msg);
            faults++;
            if (faults <= 10) $display("mismatch: %s", msg);
        endfunction

        function void compare_field(string name, logic [SAMPLE_W-1:0] want,
                                    logic [SAMPLE_W-1:0] got);
            if (want !== got)
                note_fault($sformatf("result %0d %s expected %h got %h",
                                     summaries_seen, name, want, got));
        endfunction

        function void check_summary(logic [OUT_W-1:0] word);
            run_summary_t got;
            run_summary_t want;
            got = word[SUMMARY_W-1:0];
            summaries_seen++;
            if (awaited_summaries.size() == 0) begin
                note_fault($sformatf("result %0d arrived with none pending: %h",
                                     summaries_seen, word));
                return;
            end
            want = awaited_summaries.pop_front();
            compare_field("average", want.average, got.average);
            compare_field("minimum", want.minimum, got.minimum);
            compare_field("maximum", want.maximum, got.maximum);
            compare_field("sample_count", want.sample_count, got.sample_count);
            compare_field("is_sorted", want.flags.is_sorted, got.flags.is_sorted);
            compare_field("slope_constant", want.flags.slope_constant,
                          got.flags.slope_constant);
            compare_field("empty_error", want.flags.empty_error, got.flags.empty_error);
            compare_field("count_overflow", want.flags.count_overflow,
                          got.flags.count_overflow);
            compare_field("padding", '0, word[OUT_W-1:SUMMARY_W]);
        endfunction
    endclass

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [TOL_BITS-1:0]  cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata     = '0;
    logic [1:0]           s_tuser     = ACT_SAMPLE;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [OUT_W-1:0]     m_tdata;

    run_stats_board board = new();

    int items_sent     = 0;
    int sender_idle    = 0;   // percent of cycles the sender holds back
    int receiver_idle  = 0;   // percent of cycles the receiver holds back
    int stall_request  = 0;   // long hold-off asked of the receiver, in cycles
    int stall_left     = 0;
    int quiet_cycles   = 0;

    running_column_statistics_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side: every accepted transaction goes to the scoreboard. tready is
    // drawn afresh each cycle, except during a requested hold-off when it stays low
    // for the whole stretch so the unit backs up and stalls its input.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_summary(m_tdata);
        if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= receiver_idle);
        end
    end

    // Hang detector: counts cycles with no transaction on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one input transaction, after a random gap, and wait for the handshake.
    // Returns in the time step of acceptance with tvalid still high, so a
    // back-to-back transaction needs no second assignment to tvalid here.
    task automatic send_item(input logic [1:0] action, input logic [SAMPLE_W-1:0] val);
        if ($urandom_range(0, 99) < sender_idle) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            do @(posedge aclk); while ($urandom_range(0, 99) < sender_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(val);
        s_tuser  <= action;
        do @(posedge aclk); while (!s_tready);
        board.note_item(action, IN_W'(val));
        items_sent++;
    endtask

    // Register write with the unit idle: all results drained, then time for any
    // sample still being folded in.
    task automatic retune(input logic [TOL_BITS-1:0] value);
        s_tvalid <= 1'b0;
        while (board.awaited_summaries.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.set_tolerance(value);
    endtask

    // Hand-picked runs at the default tolerance of 66/65536.
    task automatic directed_runs();
        // empty run through both finish codes
        send_item(ACT_FINISH, 32'h1234_5678);
        send_item(ACT_UNUSED, 32'hFFFF_FFFF);
        // single sample at the top of the range
        send_item(ACT_SAMPLE_FINISH, 32'h7FFF_FFFF);
        // full-range step; sum of -1 over two truncates to zero
        send_item(ACT_SAMPLE, 32'h8000_0000);
        send_item(ACT_SAMPLE, 32'h7FFF_FFFF);
        send_item(ACT_FINISH, 32'h0);
        // flat run: both slopes zero keep the constant flag, sorted drops
        send_item(ACT_SAMPLE, 32'd5);
        send_item(ACT_SAMPLE, 32'd5);
        send_item(ACT_SAMPLE_FINISH, 32'd5);
        // up then down: slopes cancel, difference nonzero
        send_item(ACT_SAMPLE, 32'd0);
        send_item(ACT_SAMPLE, 32'd10);
        send_item(ACT_SAMPLE_FINISH, 32'd0);
        // clean ramp closed by the spare code
        send_item(ACT_SAMPLE, 32'h0001_0000);
        send_item(ACT_SAMPLE, 32'h0002_0000);
        send_item(ACT_SAMPLE, 32'h0003_0000);
        send_item(ACT_UNUSED, 32'hA5A5_A5A5);
        // negative mean truncates toward zero
        send_item(ACT_SAMPLE, -32'sd7);
        send_item(ACT_SAMPLE_FINISH, 32'd0);
        // slope test exactly on the tolerance edge, then one step past it
        send_item(ACT_SAMPLE, 32'd0);
        send_item(ACT_SAMPLE, 32'd65503);
        send_item(ACT_SAMPLE_FINISH, 32'd131072);
        send_item(ACT_SAMPLE, 32'd0);
        send_item(ACT_SAMPLE, 32'd65503);
        send_item(ACT_SAMPLE_FINISH, 32'd131073);
    endtask

    // One run of random shape: exact and jittered ramps, flat, rising, falling,
    // extreme values and plain noise; mostly 3..12 samples, some empty or tiny.
    task automatic random_run();
        int                         shape;
        int                         len;
        int                         jit;
        bit                         closed;
        logic signed [SAMPLE_W-1:0] base;
        logic signed [SAMPLE_W-1:0] slope;
        logic signed [SAMPLE_W-1:0] val;
        shape  = $urandom_range(0, 9);
        len    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        base   = $signed($urandom) >>> 2;
        slope  = $signed($urandom) >>> $urandom_range(8, 20);
        jit    = $urandom_range(0, 255);
        val    = base;
        closed = 1'b0;
        for (int i = 0; i < len; i++) begin
            case (shape)
                0, 1, 2: val = base + i * slope;
                3, 4:    val = base + i * slope + $urandom_range(0, jit);
                5:       val = base;
                6:       val = $urandom;
                7: begin
                    case ($urandom_range(0, 4))
                        0:       val = 32'h7FFF_FFFF;
                        1:       val = 32'h8000_0000;
                        2:       val = 32'h0000_0000;
                        3:       val = 32'hFFFF_FFFF;
                        default: val = 32'h0001_0000;
                    endcase
                end
                8:       val = (i == 0) ? base : val + $urandom_range(1, 4096);
                default: val = (i == 0) ? base : val - $urandom_range(1, 4096);
            endcase
            if (i == len - 1 && $urandom_range(0, 1) == 1) begin
                send_item(ACT_SAMPLE_FINISH, val);
                closed = 1'b1;
            end else begin
                send_item(ACT_SAMPLE, val);
            end
        end
        if (!closed)
            send_item(($urandom_range(0, 3) == 0) ? ACT_UNUSED : ACT_FINISH, $urandom);
    endtask

    task automatic random_phase(input int count);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal) random_run();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender mostly busy, receiver mostly stalling; reset tolerance first
        sender_idle   = 9;
        receiver_idle = 82;
        directed_runs();
        retune(16'hFFFF);
        random_phase(210);

        // roles swapped, zero tolerance: any slope change clears the flag
        sender_idle   = 82;
        receiver_idle = 9;
        retune(16'h0000);
        random_phase(210);

        // no idling at all
        sender_idle   = 0;
        receiver_idle = 0;
        retune($urandom_range(0, 65535));
        random_phase(210);

        // about one percent; receiver holds off while the sender keeps offering
        retune(16'd655);
        stall_request = HOLD_CYCLES;
        random_phase(220);

        s_tvalid <= 1'b0;
        while (board.awaited_summaries.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.awaited_summaries.size() != 0)
            board.note_fault($sformatf("%0d results never arrived",
                                       board.awaited_summaries.size()));
        if (board.faults == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
sv/rcs_pkg.sv
sv/rcs_alu.sv
sv/rcs_out_buf.sv
sv/running_column_statistics_unit.sv
bench/testbench.sv
